[src/assert_macros.svh]
// Assertion macros shared by the turbo masker RTL.
// Needs a clock named clk and a reset named rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TAM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("turbo masker check failed");

// next-cycle implication
`define TAM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("turbo masker check failed");

`endif

[src/tam_pkg.sv]
// Types and constants of the turbo autofire button masker.
// No dependencies; used by every other file of the block but assert_macros.svh.
package tam_pkg;

  localparam int BUTTON_W    = 16;
  localparam int NOW_W       = 64;
  localparam int READER_W    = 4;
  localparam int MODE_W      = 3;
  localparam int MODES_W     = 48;
  localparam int MODE_SLOTS  = MODES_W / MODE_W;
  localparam int PERIOD_W    = 32;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 48;

  localparam int BIT_TRIANGLE = 2;
  localparam int BIT_START    = 4;

  localparam logic [PERIOD_W-1:0] FAST_RESET = 32'd100000;
  localparam logic [PERIOD_W-1:0] MID_RESET  = 32'd250000;
  localparam logic [PERIOD_W-1:0] SLOW_RESET = 32'd500000;

  localparam logic [MODE_W-1:0] MODE_OFF  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FAST = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MID  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SLOW = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] REG_MODES       = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FAST_PERIOD = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MID_PERIOD  = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SLOW_PERIOD = 8'd3;

  typedef struct packed {
    logic [MODES_W-1:0]  modes;
    logic [PERIOD_W-1:0] fast_period;
    logic [PERIOD_W-1:0] mid_period;
    logic [PERIOD_W-1:0] slow_period;
  } cfg_t;

  typedef struct packed {
    logic fast;
    logic mid;
    logic slow;
  } fire_t;

endpackage

[src/tam_channels.sv]
// Handshake channels of the turbo masker: poll in, result out, config write.
// Depends on tam_pkg for field widths.
interface tam_poll_if;
  logic                           valid;
  logic                           ready;
  logic [tam_pkg::BUTTON_W-1:0]   buttons_in;
  logic [tam_pkg::NOW_W-1:0]      now_us;
  logic [tam_pkg::READER_W-1:0]   reader;
  logic                           active_low;

  modport source (output valid, buttons_in, now_us, reader, active_low, input ready);
  modport sink (input valid, buttons_in, now_us, reader, active_low, output ready);
endinterface

interface tam_result_if;
  logic                         valid;
  logic                         ready;
  logic [tam_pkg::BUTTON_W-1:0] buttons_out;
  logic                         menu_request;

  modport source (output valid, buttons_out, menu_request, input ready);
  modport sink (input valid, buttons_out, menu_request, output ready);
endinterface

interface tam_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tam_pkg::CFG_INDEX_W-1:0] index;
  logic [tam_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/turbo_autofire_button_masker.sv]
// Top level of the turbo autofire button masker: input stage, timers, mask, result stage.
// Depends on tam_pkg, assert_macros.svh, the channel interfaces and tam_* modules.
//
//   channel | role   | payload
//   --------+--------+-------------------------------------------
//   poll    | in     | buttons_in, now_us, reader, active_low
//   result  | out    | buttons_out, menu_request
//   cfg     | write  | index (0 modes, 1..3 fast/mid/slow period), data
//
// One item per cycle unless the result stalls; each item passes the input register, then the result register.
// All work for an item sits between the input register and the result register,
// so state written by one item is seen by the next item.
// rst is synchronous: clears both stage valids, timers, phase bits and config registers.
// A stalled result holds the input stage; poll.ready drops only when both are full.
// cfg.ready is always high.
`include "assert_macros.svh"

module turbo_autofire_button_masker #(
  parameter int BUTTON_COUNT = 16,
  parameter int READER_COUNT = 12
) (
  input  logic          clk,
  input  logic          rst,
  tam_poll_if.sink      poll,
  tam_result_if.source  result,
  tam_cfg_if.sink       cfg
);

  tam_pkg::cfg_t  regs;
  tam_pkg::fire_t fire;

  logic                           s1_valid;
  logic [tam_pkg::BUTTON_W-1:0]   s1_buttons;
  logic [tam_pkg::NOW_W-1:0]      s1_now;
  logic [tam_pkg::READER_W-1:0]   s1_reader;
  logic                           s1_low;
  logic                           s1_adv;
  logic                           poll_take;
  logic [tam_pkg::BUTTON_W-1:0]   s1_held;
  logic                           menu;
  logic                           commit;
  logic [tam_pkg::BUTTON_W-1:0]   masked;

  logic                           out_valid;
  logic                           out_valid_next;
  logic [tam_pkg::BUTTON_W-1:0]   out_buttons;
  logic                           out_menu;

  tam_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  assign s1_adv     = s1_valid && (!out_valid || result.ready);
  assign poll.ready = !s1_valid || s1_adv;
  assign poll_take  = poll.valid && poll.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (poll.ready) begin
      s1_valid <= poll.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll_take) begin
      s1_buttons <= poll.buttons_in;
      s1_now     <= poll.now_us;
      s1_reader  <= poll.reader;
      s1_low     <= poll.active_low;
    end
  end

  assign s1_held = s1_low ? ~s1_buttons : s1_buttons;
  assign menu    = s1_held[tam_pkg::BIT_START] && s1_held[tam_pkg::BIT_TRIANGLE];
  assign commit  = s1_adv && !menu;

  tam_rate_timers u_timers (
    .clk    (clk),
    .rst    (rst),
    .now_us (s1_now),
    .regs   (regs),
    .commit (commit),
    .fire   (fire)
  );

  tam_turbo_mask #(
    .BUTTON_COUNT (BUTTON_COUNT),
    .READER_COUNT (READER_COUNT)
  ) u_mask (
    .clk         (clk),
    .rst         (rst),
    .buttons_in  (s1_buttons),
    .reader      (s1_reader),
    .active_low  (s1_low),
    .modes       (regs.modes),
    .fire        (fire),
    .commit      (commit),
    .buttons_out (masked)
  );

  always_comb begin
    out_valid_next = out_valid;
    if (s1_adv) begin
      out_valid_next = 1'b1;
    end else if (result.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_buttons <= menu ? s1_buttons : masked;
      out_menu    <= menu;
    end
  end

  assign result.valid        = out_valid;
  assign result.buttons_out  = out_buttons;
  assign result.menu_request = out_menu;

  `TAM_ASSERT_NEXT(a_menu_pass, s1_adv && menu, out_buttons == $past(s1_buttons) && out_menu)
  `TAM_ASSERT_SAME(a_stall_full, !poll.ready, s1_valid && out_valid && !result.ready)
  `TAM_ASSERT_SAME(a_out_source, $rose(out_valid), $past(s1_adv))

endmodule

[src/tam_cfg_regs.sv]
// Configuration register file: turbo modes and the three timer periods.
// Depends on tam_pkg and tam_cfg_if.
module tam_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  tam_cfg_if.sink        cfg,
  output tam_pkg::cfg_t  regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.modes       <= '0;
      regs.fast_period <= tam_pkg::FAST_RESET;
      regs.mid_period  <= tam_pkg::MID_RESET;
      regs.slow_period <= tam_pkg::SLOW_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        tam_pkg::REG_MODES:       regs.modes       <= cfg.data[tam_pkg::MODES_W-1:0];
        tam_pkg::REG_FAST_PERIOD: regs.fast_period <= cfg.data[tam_pkg::PERIOD_W-1:0];
        tam_pkg::REG_MID_PERIOD:  regs.mid_period  <= cfg.data[tam_pkg::PERIOD_W-1:0];
        tam_pkg::REG_SLOW_PERIOD: regs.slow_period <= cfg.data[tam_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[src/tam_rate_timers.sv]
// Fast, mid and slow rate timers: strict compare of elapsed time, reload on a committed fire.
// Depends on tam_pkg.
module tam_rate_timers (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [tam_pkg::NOW_W-1:0]    now_us,
  input  tam_pkg::cfg_t                regs,
  input  logic                         commit,
  output tam_pkg::fire_t               fire
);

  logic [tam_pkg::NOW_W-1:0] fast_last_time;
  logic [tam_pkg::NOW_W-1:0] mid_last_time;
  logic [tam_pkg::NOW_W-1:0] slow_last_time;

  assign fire.fast = (now_us - fast_last_time) >
                     {{(tam_pkg::NOW_W-tam_pkg::PERIOD_W){1'b0}}, regs.fast_period};
  assign fire.mid  = (now_us - mid_last_time) >
                     {{(tam_pkg::NOW_W-tam_pkg::PERIOD_W){1'b0}}, regs.mid_period};
  assign fire.slow = (now_us - slow_last_time) >
                     {{(tam_pkg::NOW_W-tam_pkg::PERIOD_W){1'b0}}, regs.slow_period};

  always_ff @(posedge clk) begin
    if (rst) begin
      fast_last_time <= '0;
      mid_last_time  <= '0;
      slow_last_time <= '0;
    end else if (commit) begin
      if (fire.fast) fast_last_time <= now_us;
      if (fire.mid)  mid_last_time  <= now_us;
      if (fire.slow) slow_last_time <= now_us;
    end
  end

endmodule

[src/tam_turbo_mask.sv]
// Per-reader turbo phase store and the button masking logic.
// Depends on tam_pkg.
module tam_turbo_mask #(
  parameter int BUTTON_COUNT = 16,
  parameter int READER_COUNT = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [tam_pkg::BUTTON_W-1:0]   buttons_in,
  input  logic [tam_pkg::READER_W-1:0]   reader,
  input  logic                           active_low,
  input  logic [tam_pkg::MODES_W-1:0]    modes,
  input  tam_pkg::fire_t                 fire,
  input  logic                           commit,
  output logic [tam_pkg::BUTTON_W-1:0]   buttons_out
);

  localparam int PhaseW = (BUTTON_COUNT < tam_pkg::MODE_SLOTS) ? BUTTON_COUNT
                                                                : tam_pkg::MODE_SLOTS;
  localparam int RowW   = (READER_COUNT > 1) ? $clog2(READER_COUNT) : 1;
  localparam logic [tam_pkg::READER_W:0] ReaderLimit = (tam_pkg::READER_W+1)'(READER_COUNT);

  logic [PhaseW-1:0]            phase [READER_COUNT];
  logic [PhaseW-1:0]            row;
  logic [PhaseW-1:0]            row_next;
  logic [tam_pkg::BUTTON_W-1:0] held;
  logic [tam_pkg::BUTTON_W-1:0] masked;
  logic [tam_pkg::MODE_W-1:0]   mode;
  logic                         ok;
  logic                         in_range;
  logic [RowW-1:0]              row_idx;

  assign in_range = {1'b0, reader} < ReaderLimit;
  assign row_idx  = reader[RowW-1:0];
  assign held     = active_low ? ~buttons_in : buttons_in;
  assign row      = in_range ? phase[row_idx] : '0;

  always_comb begin
    masked   = buttons_in;
    row_next = row;
    mode     = tam_pkg::MODE_OFF;
    ok       = 1'b0;
    for (int i = 0; i < PhaseW; i++) begin
      mode = modes[tam_pkg::MODE_W*i +: tam_pkg::MODE_W];
      case (mode)
        tam_pkg::MODE_OFF:  ok = 1'b0;
        tam_pkg::MODE_FAST: ok = fire.fast;
        tam_pkg::MODE_MID:  ok = fire.mid;
        tam_pkg::MODE_SLOW: ok = fire.slow;
        default:            ok = 1'b1;
      endcase
      if (ok) begin
        if (held[i]) begin
          row_next[i] = ~row[i];
          if (!row[i]) masked[i] = active_low;
        end else begin
          row_next[i] = 1'b0;
        end
      end
    end
  end

  assign buttons_out = in_range ? masked : buttons_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < READER_COUNT; r++) phase[r] <= '0;
    end else if (commit && in_range) begin
      phase[row_idx] <= row_next;
    end
  end

endmodule
